@@ hw/rtl/mts_pkg.sv @@
package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic    push;
        logic    pop;
        logic    refill;
        logic    result_en;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } flags_t;

endpackage

@@ hw/rtl/min_tracking_stack.sv @@
// Channel   Handshake            Word
// input     in_valid, in_ready   kind, push_value
// output    out_valid, out_ready top_value, min_value, occupancy, status
//
// A push, a refused push and a pop of an empty stack write their result when accepted.
// A pop reads the entries below the top from the value and minimum memories; the
// cached tops are reloaded in the load state, once the output register is free.
// rst_n clears the counts and the output valid; memory contents need no reset.
// The result sits in an output register and a pop of a non-empty stack is accepted while it waits.
// Besides the load state of a pop, the input stalls only while a new result
// is ready and the old one has not been taken.
module min_tracking_stack (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic [mts_pkg::DATA_WIDTH-1:0] push_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mts_pkg::DATA_WIDTH-1:0] top_value,
    output logic [mts_pkg::DATA_WIDTH-1:0] min_value,
    output logic [mts_pkg::CNT_W-1:0]      occupancy,
    output logic [1:0]                     status
);
    import mts_pkg::*;

    cmd_t   cmd;
    flags_t flags;

    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    mts_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_value (push_value),
        .flags      (flags),
        .top_value  (top_value),
        .min_value  (min_value),
        .occupancy  (occupancy),
        .status     (status)
    );

endmodule

@@ hw/rtl/mts_ctrl.sv @@
module mts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            kind,
    output logic            out_valid,
    input  logic            out_ready,
    input  mts_pkg::flags_t flags,
    output mts_pkg::cmd_t   cmd
);
    import mts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   accept;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        in_ready       = 1'b0;
        state_next     = state_reg;
        cmd            = '0;
        cmd.status     = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = slot_free || (kind == KIND_POP && !flags.empty);
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    cmd.refill    = 1'b1;
                    cmd.result_en = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        accept = in_valid && in_ready;
        if (accept)
        begin
            if (kind == KIND_PUSH)
            begin
                cmd.push      = !flags.full;
                cmd.status    = flags.full ? ST_FULL : ST_OK;
                cmd.result_en = 1'b1;
            end
            else if (flags.empty)
            begin
                cmd.status    = ST_EMPTY;
                cmd.result_en = 1'b1;
            end
            else
            begin
                cmd.pop    = 1'b1;
                state_next = S_LOAD;
            end
        end

        if (cmd.result_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_en |-> (!out_valid_reg || out_ready))
        else $error("result written over a word not yet taken");

    a_load_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> !in_ready)
        else $error("input taken while a pop is still refilling");

    a_pop_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (state_reg == S_LOAD))
        else $error("pop not followed by refill");
`endif

endmodule

@@ hw/rtl/mts_datapath.sv @@
module mts_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mts_pkg::cmd_t                   cmd,
    input  logic [mts_pkg::DATA_WIDTH-1:0]  push_value,
    output mts_pkg::flags_t                 flags,
    output logic [mts_pkg::DATA_WIDTH-1:0]  top_value,
    output logic [mts_pkg::DATA_WIDTH-1:0]  min_value,
    output logic [mts_pkg::CNT_W-1:0]       occupancy,
    output logic [1:0]                      status
);
    import mts_pkg::*;

    localparam int MW = DATA_WIDTH + CNT_W;

    logic [DATA_WIDTH-1:0] vmem [STACK_DEPTH];
    logic [MW-1:0]         mmem [STACK_DEPTH];

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      mcount_reg, mcount_next;
    logic                  drop_reg, drop_next;
    logic [DATA_WIDTH-1:0] top_reg, top_next;
    logic [DATA_WIDTH-1:0] mval_reg, mval_next;
    logic [CNT_W-1:0]      mrep_reg, mrep_next;
    logic [DATA_WIDTH-1:0] vrd_reg;
    logic [MW-1:0]         mrd_reg;
    logic [DATA_WIDTH-1:0] top_out_reg, min_out_reg;
    logic [CNT_W-1:0]      occ_out_reg;
    status_t               status_out_reg;

    logic [CNT_W-1:0]      count_m2;
    logic [CNT_W-1:0]      mcount_m1;
    logic [CNT_W-1:0]      mcount_m2;
    logic [CNT_W-1:0]      rep_dec;
    logic                  hit;
    logic                  mwr_en;
    logic [ADDR_W-1:0]     mwr_addr;
    logic [MW-1:0]         mwr_data;

    assign count_m2  = count_reg - CNT_W'(2);
    assign mcount_m1 = mcount_reg - CNT_W'(1);
    assign mcount_m2 = mcount_reg - CNT_W'(2);

    assign flags.full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign flags.empty = (count_reg == '0);

    always_comb
    begin
        count_next  = count_reg;
        mcount_next = mcount_reg;
        drop_next   = drop_reg;
        top_next    = top_reg;
        mval_next   = mval_reg;
        mrep_next   = mrep_reg;
        mwr_en      = 1'b0;
        mwr_addr    = mcount_m1[ADDR_W-1:0];
        mwr_data    = '0;
        hit         = (mcount_reg != '0) && (top_reg == mval_reg) && (mrep_reg != '0);
        rep_dec     = hit ? (mrep_reg - CNT_W'(1)) : mrep_reg;

        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            top_next   = push_value;
            if (mcount_reg == '0 || $signed(push_value) < $signed(mval_reg))
            begin
                if (mcount_reg != CNT_W'(STACK_DEPTH))
                begin
                    mcount_next = mcount_reg + CNT_W'(1);
                    mval_next   = push_value;
                    mrep_next   = CNT_W'(1);
                    mwr_en      = 1'b1;
                    mwr_addr    = mcount_reg[ADDR_W-1:0];
                    mwr_data    = {push_value, CNT_W'(1)};
                end
            end
            else if (push_value == mval_reg)
            begin
                mrep_next = mrep_reg + CNT_W'(1);
                mwr_en    = 1'b1;
                mwr_data  = {mval_reg, mrep_reg + CNT_W'(1)};
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            drop_next  = 1'b0;
            if (mcount_reg != '0)
            begin
                mrep_next = rep_dec;
                if (rep_dec == '0)
                begin
                    mcount_next = mcount_m1;
                    drop_next   = 1'b1;
                end
                else if (hit)
                begin
                    mwr_en   = 1'b1;
                    mwr_data = {mval_reg, rep_dec};
                end
            end
        end
        else if (cmd.refill)
        begin
            top_next = vrd_reg;
            if (drop_reg)
            begin
                mval_next = mrd_reg[MW-1:CNT_W];
                mrep_next = mrd_reg[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            vmem[count_reg[ADDR_W-1:0]] <= push_value;
        end
        if (cmd.pop)
        begin
            vrd_reg <= vmem[count_m2[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mwr_en)
        begin
            mmem[mwr_addr] <= mwr_data;
        end
        if (cmd.pop)
        begin
            mrd_reg <= mmem[mcount_m2[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            mcount_reg <= '0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            mcount_reg <= mcount_next;
            drop_reg   <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        mval_reg <= mval_next;
        mrep_reg <= mrep_next;
        if (cmd.result_en)
        begin
            top_out_reg    <= (count_next == '0) ? '0 : top_next;
            min_out_reg    <= (count_next == '0 || mcount_next == '0) ? '0 : mval_next;
            occ_out_reg    <= count_next;
            status_out_reg <= cmd.status;
        end
    end

    assign top_value = top_out_reg;
    assign min_value = min_out_reg;
    assign occupancy = occ_out_reg;
    assign status    = status_out_reg;

`ifndef NO_ASSERTIONS
    a_min_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        mcount_reg <= count_reg)
        else $error("minimum stack deeper than value stack");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("occupancy beyond depth");

    a_min_present: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (mcount_reg != '0))
        else $error("values held with no minimum entry");
`endif

endmodule
